### hdl/rvcl_pkg.sv
package rvcl_pkg;

  // Field widths
  localparam int DIR_W   = 32;
  localparam int RAD_W   = 40;
  localparam int OFS_W   = 24;
  localparam int INC_W   = 30;
  localparam int DIVN_W  = 33;
  localparam int PROD_W  = 64;

  // Defaults
  localparam int STEPS_DEFAULT = 64;

  // Axis below this raw magnitude has no plane crossings
  localparam logic [DIR_W-1:0] MAG_MIN = 32'd7;
  // 100000.0 in Q24.16
  localparam logic [RAD_W-1:0] FAR_RADIUS = 40'd6553600000;
  // ceil(2^37 / 100): exact divide by 100 for any 32-bit value
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int DIV100_SHIFT = 37;

  localparam logic [OFS_W-1:0] OFS_POS_LIM = 24'h7FFFFF;
  localparam logic [OFS_W-1:0] OFS_NEG_LIM = 24'h800000;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic [RAD_W-1:0]        step_length;
    logic signed [OFS_W-1:0] offset_i;
    logic signed [OFS_W-1:0] offset_j;
    logic signed [OFS_W-1:0] offset_k;
    logic                    last_step;
  } out_item_t;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/rvcl_divider.sv
module rvcl_divider
  import rvcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIR_W-1:0]  rem;
  logic [DIVN_W-1:0] quo;
  logic [DIR_W-1:0]  den;
  logic              busy;
  logic              done;

  logic [DIR_W:0]    shifted;
  logic              fits;

  // One restoring step: bring down the next dividend bit
  assign shifted = {rem, quo[DIVN_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVN_W);
        rem  <= '0;
        quo  <= req.dividend;
        den  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? DIR_W'(shifted - {1'b0, den}) : shifted[DIR_W-1:0];
        quo <= {quo[DIVN_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### hdl/ray_voxel_crossing_list_unit.sv
// Ray voxel crossing list.
// Input channel (in_valid/in_ready, in_item): one ray direction, three signed
// Q16.16 components already divided by the voxel size. in_ready is high only
// while the sequencer is idle; one ray is worked on at a time.
// Output channel (out_valid/out_ready, out_item): STEPS items per ray in order
// of nondecreasing radius, last_step set on the final one.
// Setup: each axis with a usable component runs a restoring divide for its
// radius increment. Each result then takes, per axis, two products and a sum
// of the radius by the component, a rounding add, and for the crossed axis
// one more product for the divide by 100, all through one shared 32x32
// multiplier.
// A result sits in an output register; while the receiver stalls the
// sequencer waits for the register to free up. After the last result is
// loaded the unit takes the next ray while that result still waits.
// Reset (rst, synchronous) empties the output register and idles the unit.
module ray_voxel_crossing_list_unit
  import rvcl_pkg::*;
#(
  parameter int STEPS = STEPS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_SELECT, S_MHI, S_MLO,
    S_PSUM, S_ROUND, S_MDIV, S_SAT, S_OUT
  } state_t;

  state_t state;

  logic [DIR_W-1:0] mag [3];
  logic [2:0]       neg;
  logic [INC_W-1:0] inc [3];
  logic [RAD_W-1:0] accp [3];   // (2n+1)*inc + 1
  logic [RAD_W-1:0] prev_r;
  logic [RAD_W-1:0] r_cur;
  logic [RAD_W-1:0] step_len;
  logic [1:0]       prin;
  logic [1:0]       ax;
  logic [CNT_W-1:0] step_cnt;
  logic [35:0]      ph;
  logic             sat;
  logic [56:0]      p;
  logic [30:0]      t;
  logic [OFS_W-1:0] ofs [3];
  logic [PROD_W-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [RAD_W-1:0] nr [3];
  logic [1:0]       sel;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [62:0]      q;
  logic [62:0]      rnd_add;
  logic [62:0]      rnd_sum;
  logic [30:0]      v;
  logic [OFS_W-1:0] ofs_val;
  logic             out_free;
  logic             ax_small;

  rvcl_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next crossing radius per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nr[a] = (inc[a] == '0) ? FAR_RADIUS : {1'b0, accp[a][RAD_W-1:1]};
    end
  end

  // Merge: ties go to x, then y
  always_comb begin
    if (nr[0] <= nr[1] && nr[0] <= nr[2]) sel = 2'd0;
    else if (nr[1] <= nr[2])              sel = 2'd1;
    else                                  sel = 2'd2;
  end

  // Divider request
  assign ax_small         = mag[ax] < MAG_MIN;
  assign div_req.start    = (state == S_DIV_START) && !ax_small;
  assign div_req.dividend = {1'b1, 1'b0, mag[ax][DIR_W-1:1]};
  assign div_req.divisor  = mag[ax];

  // Shared multiplier operands
  always_comb begin
    case (state)
      S_MHI:   begin mul_a = {12'b0, r_cur[39:20]}; mul_b = mag[ax]; end
      S_MLO:   begin mul_a = {12'b0, r_cur[19:0]};  mul_b = mag[ax]; end
      S_MDIV:  begin mul_a = {1'b0, t};             mul_b = DIV100_MAGIC; end
      default: begin mul_a = '0;                    mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Rounding: crossed axis gets 99/100, halves round toward plus infinity
  always_comb begin
    if (ax == prin) begin
      q       = (63'(p) << 6) + (63'(p) << 5) + (63'(p) << 1) + 63'(p);
      rnd_add = (63'(50) << 32) - 63'(neg[ax]);
    end else begin
      q       = 63'(p);
      rnd_add = (63'(1) << 31) - 63'(neg[ax]);
    end
    rnd_sum = q + rnd_add;
  end

  // Final clamp to 24 bits
  always_comb begin
    v = (ax == prin) ? 31'(prod[PROD_W-1:DIV100_SHIFT]) : t;
    if (sat) begin
      ofs_val = neg[ax] ? OFS_NEG_LIM : OFS_POS_LIM;
    end else if (neg[ax]) begin
      ofs_val = (v > 31'(OFS_NEG_LIM)) ? OFS_NEG_LIM : OFS_W'(-v[OFS_W-1:0]);
    end else begin
      ofs_val = (v > 31'(OFS_POS_LIM)) ? OFS_POS_LIM : v[OFS_W-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ax        <= '0;
      step_cnt  <= '0;
      for (int a = 0; a < 3; a++) begin
        inc[a]  <= '0;
        accp[a] <= '0;
      end
      prev_r    <= '0;
    end else begin
      // S_OUT reloads the output register itself when it frees up
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag[0] <= in_item.dir_x[31] ? DIR_W'(-in_item.dir_x) : in_item.dir_x;
            mag[1] <= in_item.dir_y[31] ? DIR_W'(-in_item.dir_y) : in_item.dir_y;
            mag[2] <= in_item.dir_z[31] ? DIR_W'(-in_item.dir_z) : in_item.dir_z;
            neg    <= {in_item.dir_z[31], in_item.dir_y[31], in_item.dir_x[31]};
            ax     <= '0;
            state  <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (ax_small) begin
            inc[ax]  <= '0;
            accp[ax] <= RAD_W'(1);
            if (ax == 2'd2) begin
              state    <= S_SELECT;
              step_cnt <= '0;
              prev_r   <= '0;
            end else begin
              ax <= ax + 1'b1;
            end
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            inc[ax]  <= div_rsp.quotient[INC_W-1:0];
            accp[ax] <= RAD_W'(div_rsp.quotient[INC_W-1:0]) + RAD_W'(1);
            if (ax == 2'd2) begin
              state    <= S_SELECT;
              step_cnt <= '0;
              prev_r   <= '0;
            end else begin
              ax    <= ax + 1'b1;
              state <= S_DIV_START;
            end
          end
        end
        S_SELECT: begin
          r_cur    <= nr[sel];
          prin     <= sel;
          step_len <= (nr[sel] >= prev_r) ? nr[sel] - prev_r : '0;
          ax       <= '0;
          state    <= S_MHI;
        end
        S_MHI: begin
          state <= S_MLO;
        end
        S_MLO: begin
          ph    <= prod[35:0];
          sat   <= |prod[51:36];
          state <= S_PSUM;
        end
        S_PSUM: begin
          p     <= {1'b0, ph, 20'b0} + 57'(prod[51:0]);
          state <= S_ROUND;
        end
        S_ROUND: begin
          t     <= rnd_sum[62:32];
          state <= (ax == prin) ? S_MDIV : S_SAT;
        end
        S_MDIV: begin
          state <= S_SAT;
        end
        S_SAT: begin
          ofs[ax] <= ofs_val;
          if (ax == 2'd2) begin
            state <= S_OUT;
          end else begin
            ax    <= ax + 1'b1;
            state <= S_MHI;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item.step_length <= step_len;
            out_item.offset_i    <= ofs[0];
            out_item.offset_j    <= ofs[1];
            out_item.offset_k    <= ofs[2];
            out_item.last_step   <= (step_cnt == CNT_W'(STEPS - 1));
            prev_r               <= r_cur;
            accp[prin]           <= accp[prin] + RAD_W'({inc[prin], 1'b0});
            if (step_cnt == CNT_W'(STEPS - 1)) begin
              state <= S_IDLE;
            end else begin
              step_cnt <= step_cnt + 1'b1;
              state    <= S_SELECT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Crossings come out in nondecreasing radius within a ray
  a_radius_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SELECT && step_cnt != '0) |-> (nr[sel] >= prev_r))
    else $error("crossing radius went backwards");

  // The divider is only ever busy during setup
  a_div_setup_only: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_DIV_WAIT))
    else $error("divider busy outside setup");

  // A taken ray drops ready at once
  a_ray_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a ray was taken");
`endif

endmodule
